// ===== rtl/core/xcr_pkg.sv =====
package xcr_pkg;

  // Input word: one byte of an entity body
  typedef struct packed {
    logic [7:0] entity_char;
    logic       has_char;
    logic       is_last;
  } in_word_t;

  // Output word: one UTF-8 byte or one error
  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] err_code;
    logic       last_byte;
  } out_word_t;

  typedef enum logic [2:0] {
    ErrNone      = 3'd0,
    ErrName      = 3'd1,
    ErrEmpty     = 3'd2,
    ErrDigit     = 3'd3,
    ErrOverflow  = 3'd4,
    ErrCodePoint = 3'd5
  } err_e;

  localparam int unsigned NumNames = 5;
  localparam int unsigned ValW     = 21;
  localparam int unsigned AccW     = 25;

  localparam logic [ValW-1:0] CodeMax   = 21'h10FFFF;
  localparam logic [ValW-1:0] SurrLo    = 21'h00D800;
  localparam logic [ValW-1:0] SurrHi    = 21'h00DFFF;
  localparam logic [ValW-1:0] Max1Byte  = 21'h00007F;
  localparam logic [ValW-1:0] Max2Byte  = 21'h0007FF;
  localparam logic [ValW-1:0] Max3Byte  = 21'h00FFFF;

  localparam logic [7:0] ChHash = 8'h23;
  localparam logic [7:0] ChLowX = 8'h78;
  localparam logic [7:0] ChUpX  = 8'h58;
  localparam logic [7:0] Ch0    = 8'h30;
  localparam logic [7:0] Ch9    = 8'h39;
  localparam logic [7:0] ChLowA = 8'h61;
  localparam logic [7:0] ChLowF = 8'h66;
  localparam logic [7:0] ChUpA  = 8'h41;
  localparam logic [7:0] ChUpF  = 8'h46;

  // Named entities, index 0..4: amp, lt, gt, quot, apos
  localparam logic [NumNames-1:0][3:0][7:0] NameText = {
    {8'h73, 8'h6F, 8'h70, 8'h61},   // apos
    {8'h74, 8'h6F, 8'h75, 8'h71},   // quot
    {8'h00, 8'h00, 8'h74, 8'h67},   // gt
    {8'h00, 8'h00, 8'h74, 8'h6C},   // lt
    {8'h00, 8'h70, 8'h6D, 8'h61}    // amp
  };
  localparam logic [NumNames-1:0][2:0] NameLen = {3'd4, 3'd4, 3'd2, 3'd2, 3'd3};
  localparam logic [NumNames-1:0][7:0] NameOut = {8'h27, 8'h22, 8'h3E, 8'h3C, 8'h26};

endpackage

// ===== rtl/core/xml_char_reference_decoder.sv =====
// XML character reference decoder.
// Input channel (in_valid_i / in_stall_o / in_word_i): one byte of an entity
// body per word, is_last on the final one; has_char 0 with is_last ends the
// entity without adding a byte.
// Output channel (out_valid_o / out_stall_i / out_word_o): the UTF-8 bytes of
// the decoded character, 1 to 4 words, or one error word; last_byte marks the
// final word of the entity.
// The first result word is valid the cycle after the ending word is
// accepted. Throughput: one input word per cycle unless an ending word is
// stalled; the parse state updates in the accepting cycle. Results leave a
// 4-entry result buffer at one word per cycle, so an ending word waits until
// the previous entity's results are down to the one being taken; non-ending
// words are never held. When the receiver stalls, the current result word
// holds and further ending words are stalled once the buffer is occupied.
// Reset clears the parse state (all names live, decimal mode, no error) and
// empties the result buffer.
module xml_char_reference_decoder
  import xcr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  // parse state
  logic [2:0]          cnt_q, cnt_d;
  logic [NumNames-1:0] cand_q, cand_d;
  logic                num_q, num_d;
  logic                hex_q, hex_d;
  logic [ValW-1:0]     val_q, val_d;
  err_e                serr_q, serr_d;

  // result buffer
  logic [7:0] buf_q [4];
  err_e       oerr_q;
  logic [2:0] ocnt_q;
  logic [1:0] idx_q;

  // per-word working values
  logic                in_acc, take, done, out_take, buf_free;
  logic [7:0]          c;
  logic [2:0]          pos, t_cnt;
  logic [NumNames-1:0] t_cand;
  logic                t_num, t_hex;
  logic [ValW-1:0]     t_val;
  err_e                t_err;
  logic                dig_ok;
  logic [3:0]          dig;
  logic [AccW-1:0]     nxt;
  logic                name_hit;
  logic [7:0]          name_byte;
  err_e                res_err;
  logic [2:0]          res_n;
  logic [7:0]          res_b [4];

  assign out_take    = out_valid_o && !out_stall_i;
  assign buf_free    = (ocnt_q == 3'd0) || (ocnt_q == 3'd1 && !out_stall_i);
  assign in_stall_o  = in_word_i.is_last && !buf_free;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign take        = in_acc && in_word_i.has_char;
  assign done        = in_acc && in_word_i.is_last;
  assign c           = in_word_i.entity_char;
  assign pos         = cnt_q;

  // digit decode in the current base
  always_comb begin
    dig_ok = 1'b1;
    dig    = 4'd0;
    if (c inside {[Ch0:Ch9]}) begin
      dig = 4'(c - Ch0);
    end else if (hex_q && (c inside {[ChLowA:ChLowF]})) begin
      dig = 4'(c - ChLowA + 8'd10);
    end else if (hex_q && (c inside {[ChUpA:ChUpF]})) begin
      dig = 4'(c - ChUpA + 8'd10);
    end else begin
      dig_ok = 1'b0;
    end
  end

  // accumulator: times 16 is a shift, times 10 is two shifted adds
  always_comb begin
    if (hex_q) begin
      nxt = {val_q, 4'b0000} + AccW'(dig);
    end else begin
      nxt = AccW'({val_q, 3'b000}) + AccW'({val_q, 1'b0}) + AccW'(dig);
    end
  end

  // state after taking this byte
  always_comb begin
    t_cnt  = cnt_q;
    t_cand = cand_q;
    t_num  = num_q;
    t_hex  = hex_q;
    t_val  = val_q;
    t_err  = serr_q;
    if (take) begin
      for (int k = 0; k < NumNames; k++) begin
        if (!(pos < NameLen[k] && NameText[k][pos[1:0]] == c)) begin
          t_cand[k] = 1'b0;
        end
      end
      if (pos == 3'd0 && c == ChHash) begin
        t_num = 1'b1;
      end else if (num_q && serr_q == ErrNone) begin
        if (pos == 3'd1 && (c == ChLowX || c == ChUpX)) begin
          t_hex = 1'b1;
        end else if (!dig_ok) begin
          t_err = ErrDigit;
        end else if (nxt > AccW'(CodeMax)) begin
          t_err = ErrOverflow;
        end else begin
          t_val = nxt[ValW-1:0];
        end
      end
      t_cnt = (pos < 3'd7) ? pos + 3'd1 : 3'd7;
    end
  end

  // named entity match at the end
  always_comb begin
    name_hit  = 1'b0;
    name_byte = 8'h00;
    for (int k = 0; k < NumNames; k++) begin
      if (!name_hit && t_cand[k] && NameLen[k] == t_cnt) begin
        name_hit  = 1'b1;
        name_byte = NameOut[k];
      end
    end
  end

  // final checks and UTF-8 encode
  always_comb begin
    res_err = ErrNone;
    res_n   = 3'd1;
    for (int i = 0; i < 4; i++) begin
      res_b[i] = 8'h00;
    end
    if (name_hit) begin
      res_b[0] = name_byte;
    end else begin
      if (t_num && t_cnt >= 3'd2) begin
        if (t_err != ErrNone) begin
          res_err = t_err;
        end else if (t_hex && t_cnt == 3'd2) begin
          res_err = ErrEmpty;
        end else if (t_val == '0 || t_val > CodeMax ||
                     (t_val >= SurrLo && t_val <= SurrHi)) begin
          res_err = ErrCodePoint;
        end
      end else begin
        res_err = ErrName;
      end
      if (res_err != ErrNone) begin
        res_n = 3'd1;
      end else if (t_val <= Max1Byte) begin
        res_b[0] = {1'b0, t_val[6:0]};
      end else if (t_val <= Max2Byte) begin
        res_n    = 3'd2;
        res_b[0] = {3'b110, t_val[10:6]};
        res_b[1] = {2'b10, t_val[5:0]};
      end else if (t_val <= Max3Byte) begin
        res_n    = 3'd3;
        res_b[0] = {4'b1110, t_val[15:12]};
        res_b[1] = {2'b10, t_val[11:6]};
        res_b[2] = {2'b10, t_val[5:0]};
      end else begin
        res_n    = 3'd4;
        res_b[0] = {5'b11110, t_val[20:18]};
        res_b[1] = {2'b10, t_val[17:12]};
        res_b[2] = {2'b10, t_val[11:6]};
        res_b[3] = {2'b10, t_val[5:0]};
      end
    end
  end

  // next parse state: cleared after every entity
  always_comb begin
    if (done) begin
      cnt_d  = 3'd0;
      cand_d = '1;
      num_d  = 1'b0;
      hex_d  = 1'b0;
      val_d  = '0;
      serr_d = ErrNone;
    end else begin
      cnt_d  = t_cnt;
      cand_d = t_cand;
      num_d  = t_num;
      hex_d  = t_hex;
      val_d  = t_val;
      serr_d = t_err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 3'd0;
      cand_q <= '1;
      num_q  <= 1'b0;
      hex_q  <= 1'b0;
      val_q  <= '0;
      serr_q <= ErrNone;
    end else begin
      cnt_q  <= cnt_d;
      cand_q <= cand_d;
      num_q  <= num_d;
      hex_q  <= hex_d;
      val_q  <= val_d;
      serr_q <= serr_d;
    end
  end

  // result buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocnt_q <= 3'd0;
      idx_q  <= 2'd0;
    end else if (done) begin
      ocnt_q <= res_n;
      idx_q  <= 2'd0;
    end else if (out_take) begin
      ocnt_q <= ocnt_q - 3'd1;
      idx_q  <= idx_q + 2'd1;
    end
  end

  // result buffer payload
  always_ff @(posedge clk_i) begin
    if (done) begin
      for (int i = 0; i < 4; i++) begin
        buf_q[i] <= res_b[i];
      end
      oerr_q <= res_err;
    end
  end

  assign out_valid_o          = (ocnt_q != 3'd0);
  assign out_word_o.out_byte  = buf_q[idx_q];
  assign out_word_o.err_code  = oerr_q;
  assign out_word_o.last_byte = (ocnt_q == 3'd1);

  // checks
  a_ocnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q <= 3'd4)
    else $error("result count out of range");

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.err_code != ErrNone) |-> ocnt_q == 3'd1)
    else $error("error result not single");

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty buffer");

  a_clear_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> (cnt_q == 3'd0 && cand_q == '1 && serr_q == ErrNone))
    else $error("parse state not cleared after entity");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_take && ocnt_q > 3'd1) |=> out_valid_o)
    else $error("result words dropped");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import xcr_pkg::*;

  typedef logic [7:0] body_q_t [$];

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandomWords = 24;
  localparam logic [20:0] CodeTop = 21'h10FFFF;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  // Expected UTF-8 / error words, oldest first
  out_word_t utf8_expected [$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned words_sent = 0;
  int unsigned burst_left = 1;
  bit          no_gaps = 1'b0;

  // Predictor copy of the parse state
  logic [2:0]  ent_count;
  logic [4:0]  ent_live;
  logic        ent_numeric;
  logic        ent_hex;
  logic [20:0] ent_value;
  err_e        ent_error;

  xml_char_reference_decoder dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Named entity tables: amp, lt, gt, quot, apos
  function automatic int unsigned name_len(int k);
    case (k)
      0: return 3;
      1, 2: return 2;
      default: return 4;
    endcase
  endfunction

  function automatic logic [7:0] name_byte(int k, logic [1:0] p);
    logic [31:0] t;
    case (k)
      0: t = {"amp", 8'h00};
      1: t = {"lt", 16'h0000};
      2: t = {"gt", 16'h0000};
      3: t = "quot";
      default: t = "apos";
    endcase
    return t[31 - 8 * p -: 8];
  endfunction

  function automatic logic [7:0] name_glyph(int k);
    case (k)
      0: return 8'h26;   // &
      1: return 8'h3C;   // <
      2: return 8'h3E;   // >
      3: return 8'h22;   // double quote
      default: return 8'h27;   // single quote
    endcase
  endfunction

  function automatic void clear_entity();
    ent_count   = '0;
    ent_live    = 5'b11111;
    ent_numeric = 1'b0;
    ent_hex     = 1'b0;
    ent_value   = '0;
    ent_error   = ErrNone;
  endfunction

  function automatic void push_result(logic [7:0] b, err_e e, logic last);
    out_word_t r;
    r.out_byte  = b;
    r.err_code  = e;
    r.last_byte = last;
    utf8_expected.insert(utf8_expected.size(), r);
  endfunction

  // One body byte: narrow the name candidates, then run the numeric parser
  function automatic void absorb_byte(logic [7:0] c);
    logic [2:0]  pos;
    int unsigned base;
    int unsigned digit;
    int unsigned nxt;
    bit          ok;
    pos = ent_count;
    for (int k = 0; k < 5; k++) begin
      if (ent_live[k] && !(pos < name_len(k) && name_byte(k, pos[1:0]) == c))
        ent_live[k] = 1'b0;
    end
    if (pos == 0 && c == "#") begin
      ent_numeric = 1'b1;
    end else if (ent_numeric && ent_error == ErrNone) begin
      if (pos == 1 && (c == "x" || c == "X")) begin
        ent_hex = 1'b1;
      end else begin
        base  = ent_hex ? 16 : 10;
        ok    = 1'b1;
        digit = 0;
        if (c >= "0" && c <= "9") digit = c - "0";
        else if (ent_hex && c >= "a" && c <= "f") digit = 10 + c - "a";
        else if (ent_hex && c >= "A" && c <= "F") digit = 10 + c - "A";
        else ok = 1'b0;
        if (!ok) begin
          ent_error = ErrDigit;
        end else begin
          nxt = ent_value * base + digit;
          if (nxt > CodeTop) ent_error = ErrOverflow;
          else ent_value = nxt[20:0];
        end
      end
    end
    ent_count = (pos < 7) ? pos + 3'd1 : 3'd7;
  endfunction

  // End of entity: named match, else numeric value or one error word
  function automatic void finish_entity();
    err_e        err;
    logic [20:0] v;
    for (int k = 0; k < 5; k++) begin
      if (ent_live[k] && name_len(k) == ent_count) begin
        push_result(name_glyph(k), ErrNone, 1'b1);
        clear_entity();
        return;
      end
    end
    v   = ent_value;
    err = ErrNone;
    if (ent_numeric && ent_count >= 2) begin
      if (ent_error != ErrNone) err = ent_error;
      else if (ent_hex && ent_count == 2) err = ErrEmpty;
      else if (v == 0 || v > CodeTop || (v >= 21'hD800 && v <= 21'hDFFF)) err = ErrCodePoint;
    end else begin
      err = ErrName;
    end
    if (err != ErrNone) begin
      push_result(8'h00, err, 1'b1);
    end else if (v <= 21'h7F) begin
      push_result(v[7:0], ErrNone, 1'b1);
    end else if (v <= 21'h7FF) begin
      push_result({3'b110, v[10:6]}, ErrNone, 1'b0);
      push_result({2'b10, v[5:0]}, ErrNone, 1'b1);
    end else if (v <= 21'hFFFF) begin
      push_result({4'b1110, v[15:12]}, ErrNone, 1'b0);
      push_result({2'b10, v[11:6]}, ErrNone, 1'b0);
      push_result({2'b10, v[5:0]}, ErrNone, 1'b1);
    end else begin
      push_result({5'b11110, v[20:18]}, ErrNone, 1'b0);
      push_result({2'b10, v[17:12]}, ErrNone, 1'b0);
      push_result({2'b10, v[11:6]}, ErrNone, 1'b0);
      push_result({2'b10, v[5:0]}, ErrNone, 1'b1);
    end
    clear_entity();
  endfunction

  function automatic void decode_word(in_word_t w);
    if (w.has_char) absorb_byte(w.entity_char);
    if (w.is_last) finish_entity();
  endfunction

  // Send one word; valid stays high after acceptance unless a gap follows
  task automatic send_word(in_word_t w);
    int unsigned gap;
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_word(w);
    if (w.has_char || w.is_last) words_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic sender_idle();
    in_valid <= 1'b0;
  endtask

  // Whole entity body; empty_end closes it with a word that carries no byte
  task automatic send_body(body_q_t b, bit empty_end, bit noisy);
    in_word_t w;
    for (int i = 0; i < b.size(); i++) begin
      if (noisy && $urandom_range(0, 3) == 0) begin
        w.entity_char = 8'($urandom_range(0, 255));
        w.has_char    = 1'b0;
        w.is_last     = 1'b0;
        send_word(w);
      end
      w.entity_char = b[i];
      w.has_char    = 1'b1;
      w.is_last     = !empty_end && (i == b.size() - 1);
      send_word(w);
    end
    if (empty_end || b.size() == 0) begin
      w.entity_char = 8'($urandom_range(0, 255));
      w.has_char    = 1'b0;
      w.is_last     = 1'b1;
      send_word(w);
    end
  endtask

  task automatic send_text(string s, bit empty_end);
    body_q_t b;
    for (int i = 0; i < s.len(); i++) b.insert(b.size(), s[i]);
    send_body(b, empty_end, 1'b0);
  endtask

  // "#<digits>" or "#x<digits>" for a value, with optional leading zeros
  task automatic numeric_body(input int unsigned v, input bit hex, input bit upper,
                              input int unsigned zeros, output body_q_t b);
    body_q_t     digits;
    int unsigned base;
    int unsigned d;
    logic [7:0]  ch;
    b = {};
    b.insert(b.size(), "#");
    if (hex) b.insert(b.size(), upper ? "X" : "x");
    repeat (zeros) b.insert(b.size(), "0");
    base = hex ? 16 : 10;
    if (v == 0) digits.insert(digits.size(), "0");
    while (v != 0) begin
      d  = v % base;
      ch = (d < 10) ? 8'(8'h30 + d) : 8'((upper ? 8'h41 : 8'h61) + d - 10);
      digits.push_front(ch);
      v = v / base;
    end
    foreach (digits[i]) b.insert(b.size(), digits[i]);
  endtask

  task automatic test_named_entities();
    send_text("amp", 1'b0);
    send_text("lt", 1'b0);
    send_text("gt", 1'b1);
    send_text("quot", 1'b0);
    send_text("apos", 1'b1);
    send_text("Amp", 1'b0);
    send_text("am", 1'b0);
    send_text("ampx", 1'b0);
    send_text("aps", 1'b0);
  endtask

  task automatic test_special_bodies();
    send_text("", 1'b0);
    send_text("#", 1'b0);
    send_text("#", 1'b1);
    send_text("#x", 1'b0);
    send_text("#X", 1'b1);
  endtask

  task automatic test_numeric_values();
    body_q_t     b;
    int unsigned vals [15] = '{0, 'h41, 'h7F, 'h80, 'h7FF, 'h800, 'hD7FF, 'hD800,
                               'hDFFF, 'hE000, 'hFFFF, 'h10000, 'h10FFFF, 'h110000,
                               'h1FFFFF};
    foreach (vals[i]) begin
      numeric_body(vals[i], i[0], i[1], 0, b);
      send_body(b, 1'b0, 1'b0);
    end
  endtask

  task automatic test_bad_digits();
    body_q_t b;
    send_text("#1a", 1'b0);
    send_text("#x1g", 1'b0);
    send_text("#12x", 1'b0);
    send_text("#xx1", 1'b0);
    send_text("#x1G5", 1'b0);
    send_text("#9999999z", 1'b0);
    send_text("#-1", 1'b0);
    b = '{"#", 8'hFF};
    send_body(b, 1'b0, 1'b0);
    b = '{"#", "x", 8'h80, "1"};
    send_body(b, 1'b1, 1'b0);
  endtask

  task automatic test_long_bodies();
    send_text("quotation", 1'b0);
    send_text("apostrophe", 1'b1);
    send_text("#00065", 1'b0);
    send_text("#x0010FFFF", 1'b0);
  endtask

  // Ending words back to back so the result buffer fills
  task automatic test_back_to_back();
    no_gaps = 1'b1;
    repeat (4) send_text("", 1'b0);
    repeat (3) send_text("#x10FFFF", 1'b0);
    repeat (2) send_text("lt", 1'b0);
    no_gaps = 1'b0;
  endtask

  task automatic test_drain_pause();
    send_text("#x1F600", 1'b0);
    sender_idle();
    while (utf8_expected.size() != 0) @(posedge clk);
    send_text("amp", 1'b0);
  endtask

  task automatic test_random_entities();
    body_q_t     b;
    int unsigned start;
    int unsigned kind;
    int unsigned k;
    int unsigned v;
    int unsigned len;
    bit          hex;
    start = words_sent;
    while (words_sent - start < RandomWords) begin
      kind = $urandom_range(0, 9);
      b = {};
      case (kind)
        0, 1, 2: begin
          k = $urandom_range(0, 4);
          for (int p = 0; p < name_len(k); p++) b.insert(b.size(), name_byte(k, 2'(p)));
          if ($urandom_range(0, 5) == 0)
            b[$urandom_range(0, b.size() - 1)] = 8'($urandom_range(0, 255));
          else if ($urandom_range(0, 7) == 0)
            b.insert(b.size(), 8'($urandom_range(0, 255)));
        end
        3, 4, 5, 6, 7: begin
          case ($urandom_range(0, 6))
            0: v = $urandom_range(1, 'h7F);
            1: v = $urandom_range('h80, 'h7FF);
            2: v = $urandom_range('h800, 'hFFFF);
            3: v = $urandom_range('h10000, 'h10FFFF);
            4: v = $urandom_range('hD800, 'hDFFF);
            5: v = $urandom_range('h10FFF0, 'h110010);
            default: v = $urandom_range(0, 2);
          endcase
          hex = (kind >= 5);
          numeric_body(v, hex, 1'($urandom_range(0, 1)),
                       ($urandom_range(0, 5) == 0) ? 2 : 0, b);
        end
        8: begin
          // broken numeric: one byte replaced, or a long run of digits
          hex = 1'($urandom_range(0, 1));
          numeric_body($urandom_range(1, 'h10FFFF), hex, 1'($urandom_range(0, 1)), 0, b);
          if ($urandom_range(0, 1) == 0) begin
            b[$urandom_range(1, b.size() - 1)] = 8'($urandom_range(0, 255));
          end else begin
            len = $urandom_range(7, 10);
            repeat (len) b.insert(b.size(), hex ? "F" : "9");
          end
        end
        default: begin
          len = $urandom_range(0, 9);
          if ($urandom_range(0, 1) == 0) b.insert(b.size(), "#");
          repeat (len) b.insert(b.size(), 8'($urandom_range(0, 255)));
        end
      endcase
      send_body(b, ($urandom_range(0, 5) == 0), ($urandom_range(0, 4) == 0));
    end
  endtask

  // Receiver stall: phases of no stall, light, heavy and run-length stalling
  int unsigned stall_mode = 0;
  int unsigned phase_left = 0;
  int unsigned run_left = 0;
  bit          run_on = 1'b0;

  always @(posedge clk) begin
    if (phase_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      phase_left = $urandom_range(20, 80);
    end
    phase_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: begin
        if (run_left == 0) begin
          run_on   = !run_on;
          run_left = $urandom_range(1, 8);
        end
        run_left--;
        out_stall <= run_on;
      end
    endcase
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin : check_results
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (utf8_expected.size() == 0) begin
        $display("%0t: unexpected word, expected none, got %h", $time, out_word);
        error_count++;
      end else begin
        want = utf8_expected.pop_front();
        if (out_word.out_byte !== want.out_byte) begin
          $display("%0t: out_byte expected %h, got %h", $time, want.out_byte,
                   out_word.out_byte);
          error_count++;
        end
        if (out_word.err_code !== want.err_code) begin
          $display("%0t: err_code expected %0d, got %0d", $time, want.err_code,
                   out_word.err_code);
          error_count++;
        end
        if (out_word.last_byte !== want.last_byte) begin
          $display("%0t: last_byte expected %b, got %b", $time, want.last_byte,
                   out_word.last_byte);
          error_count++;
        end
      end
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    clear_entity();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_named_entities();
    test_special_bodies();
    test_numeric_values();
    test_bad_digits();
    test_long_bodies();
    test_back_to_back();
    test_drain_pause();
    test_random_entities();
    sender_idle();
    while (utf8_expected.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/xcr_pkg.sv
rtl/core/xml_char_reference_decoder.sv
tb/tb_top.sv
